@@ sv/gdfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfs_pkg: shared definitions for the grid DFS explore step
// Grid and stack sizes, direction tables, result codes and sequencer states.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int GRID_COLS   = 64;
  localparam int GRID_ROWS   = 64;
  localparam int STACK_DEPTH = 4096;

  localparam int COORD_W = 6;
  localparam int MASK_W  = 8;
  localparam int DIR_W   = 3;
  localparam int DCNT_W  = DIR_W + 1;

  localparam int VIS_DEPTH = GRID_COLS * GRID_ROWS;
  localparam int VIS_AW    = $clog2(VIS_DEPTH);
  localparam int STK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    MK_ADVANCE   = 2'd0,
    MK_BACKTRACK = 2'd1,
    MK_STUCK     = 2'd2
  } move_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_DONE
  } state_t;

  // Neighbor lookup result: inside the grid, and its visited-map address
  typedef struct packed {
    logic              ok;
    logic [VIS_AW-1:0] addr;
  } nbr_info_t;

  // Priority order of the eight directions
  function automatic logic signed [1:0] dir_dx(input logic [DIR_W-1:0] d);
    logic signed [1:0] v;
    case (d)
      3'd0:    v = 2'sd1;
      3'd1:    v = 2'sd1;
      3'd2:    v = 2'sd0;
      3'd3:    v = 2'sd1;
      3'd4:    v = 2'sd0;
      3'd5:    v = -2'sd1;
      3'd6:    v = -2'sd1;
      3'd7:    v = -2'sd1;
      default: v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [DIR_W-1:0] d);
    logic signed [1:0] v;
    case (d)
      3'd0:    v = 2'sd1;
      3'd1:    v = 2'sd0;
      3'd2:    v = 2'sd1;
      3'd3:    v = -2'sd1;
      3'd4:    v = -2'sd1;
      3'd5:    v = 2'sd1;
      3'd6:    v = 2'sd0;
      3'd7:    v = -2'sd1;
      default: v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/gdfs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gdfs_ram #(
  parameter int  WIDTH = 1,
  parameter int  DEPTH = 2,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/gdfs_nbr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfs_nbr: neighbor cell lookup
// Offset the current cell by one direction, bound-check it against the grid
// and form its visited-map address (row-major).
// ----------------------------------------------------------------------------
module gdfs_nbr (
  input  logic [gdfs_pkg::COORD_W-1:0] col,
  input  logic [gdfs_pkg::COORD_W-1:0] row,
  input  logic [gdfs_pkg::DIR_W-1:0]   dir,
  output gdfs_pkg::nbr_info_t          info
);

  logic signed [1:0] dx;
  logic signed [1:0] dy;
  logic signed [7:0] nc;
  logic signed [7:0] nr;
  logic              col_ok;
  logic              row_ok;

  always_comb begin
    dx = gdfs_pkg::dir_dx(dir);
    dy = gdfs_pkg::dir_dy(dir);
    nc = signed'({2'b00, col}) + {{6{dx[1]}}, dx};
    nr = signed'({2'b00, row}) + {{6{dy[1]}}, dy};
    // negative coordinates show up in the sign bit
    col_ok = !nc[7] && (int'(nc[6:0]) < gdfs_pkg::GRID_COLS);
    row_ok = !nr[7] && (int'(nr[6:0]) < gdfs_pkg::GRID_ROWS);
    info.ok   = col_ok && row_ok;
    info.addr = gdfs_pkg::VIS_AW'(gdfs_pkg::VIS_AW'(nr[6:0])
                * gdfs_pkg::VIS_AW'(gdfs_pkg::GRID_COLS))
                + gdfs_pkg::VIS_AW'(nc[6:0]);
  end

endmodule

@@ sv/grid_dfs_explore_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dfs_explore_step: one step of depth-first exploration on a grid
// Visited map and direction stack live in block RAM; a sequencer probes the
// eight neighbors in priority order, unless the stack is full, and pushes or pops at most one direction.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid / in_stall): current cell and 8-bit walkable mask.
//   Output beat (out_valid / out_stall): move kind and step dx, dy.
//   Exactly one output beat per input beat, in order.
//   Each beat is worked alone. Per beat: an idle/accept state, a scan that
//   probes the directions in priority order and resolves the last visited
//   read, the stack read states (POP_RD, POP_WAIT) when a pop is needed,
//   and the done state that loads the output register. The scan is bounded
//   by the single read port of the visited memory.
//   A result waits in the output register while the next input beat is
//   accepted and scanned; a new result is only loaded once the register is
//   free, so a stalling receiver eventually stalls the input side too.
//   After reset the visited memory is swept to zero, one cell per cycle;
//   in_stall stays high meanwhile.
//   The direction stack is not cleared: an entry is read only after a push.
// ----------------------------------------------------------------------------
module grid_dfs_explore_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gdfs_pkg::COORD_W-1:0]        in_cur_col,
  input  logic [gdfs_pkg::COORD_W-1:0]        in_cur_row,
  input  logic [gdfs_pkg::MASK_W-1:0]         in_walkable_mask,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_move_kind,
  output logic signed [1:0]                   out_step_dx,
  output logic signed [1:0]                   out_step_dy
);

  localparam int VAW = gdfs_pkg::VIS_AW;
  localparam int SAW = gdfs_pkg::STK_AW;
  localparam int CW  = gdfs_pkg::CNT_W;

  // Sequencer state and its counters
  gdfs_pkg::state_t state_r, state_nxt;
  logic [VAW-1:0]                 clr_addr_r, clr_addr_nxt;
  logic [gdfs_pkg::DCNT_W-1:0]    dir_r, dir_nxt;
  logic                           pend_r, pend_nxt;
  logic [gdfs_pkg::DIR_W-1:0]     pend_dir_r, pend_dir_nxt;
  logic [VAW-1:0]                 pend_addr_r, pend_addr_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;

  // Latched input beat
  logic [gdfs_pkg::COORD_W-1:0]   col_r, col_nxt;
  logic [gdfs_pkg::COORD_W-1:0]   row_r, row_nxt;
  logic [gdfs_pkg::MASK_W-1:0]    mask_r, mask_nxt;

  // Staged result and output register
  gdfs_pkg::move_kind_t           res_kind_r, res_kind_nxt;
  logic signed [1:0]              res_dx_r, res_dx_nxt;
  logic signed [1:0]              res_dy_r, res_dy_nxt;
  logic                           out_valid_r, out_valid_nxt;
  gdfs_pkg::move_kind_t           out_kind_r, out_kind_nxt;
  logic signed [1:0]              out_dx_r, out_dx_nxt;
  logic signed [1:0]              out_dy_r, out_dy_nxt;

  // Memory ports
  logic                           vis_we;
  logic [VAW-1:0]                 vis_waddr;
  logic                           vis_wdata;
  logic                           vis_rdata;
  logic                           stk_we;
  logic [SAW-1:0]                 stk_waddr;
  logic [gdfs_pkg::DIR_W-1:0]     stk_wdata;
  logic [SAW-1:0]                 stk_raddr;
  logic [gdfs_pkg::DIR_W-1:0]     stk_rdata;

  gdfs_pkg::nbr_info_t            nbr;
  logic                           cand;
  logic                           cnt_full;
  logic [CW-1:0]                  cnt_dec;
  logic signed [1:0]              pop_dx;
  logic signed [1:0]              pop_dy;

  // Visited map: one bit per cell
  gdfs_ram #(
    .WIDTH (1),
    .DEPTH (gdfs_pkg::VIS_DEPTH)
  ) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (nbr.addr),
    .rdata (vis_rdata)
  );

  // Direction stack: push at cnt, pop from cnt-1
  gdfs_ram #(
    .WIDTH (gdfs_pkg::DIR_W),
    .DEPTH (gdfs_pkg::STACK_DEPTH)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Neighbor of the direction being probed this cycle
  gdfs_nbr u_nbr (
    .col  (col_r),
    .row  (row_r),
    .dir  (dir_r[gdfs_pkg::DIR_W-1:0]),
    .info (nbr)
  );

  assign cnt_full  = (cnt_r == CW'(gdfs_pkg::STACK_DEPTH));
  assign cnt_dec   = cnt_r - CW'(1);
  // Probe only in-range, walkable, in-grid directions
  assign cand      = !dir_r[gdfs_pkg::DIR_W] && mask_r[dir_r[gdfs_pkg::DIR_W-1:0]] && nbr.ok;
  assign stk_waddr = cnt_r[SAW-1:0];
  assign stk_wdata = pend_dir_r;
  assign stk_raddr = cnt_dec[SAW-1:0];
  // Backtrack reverses the popped direction
  assign pop_dx    = -gdfs_pkg::dir_dx(stk_rdata);
  assign pop_dy    = -gdfs_pkg::dir_dy(stk_rdata);

  assign in_stall      = (state_r != gdfs_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_move_kind = out_kind_r;
  assign out_step_dx   = out_dx_r;
  assign out_step_dy   = out_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdfs_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      dir_r       <= '0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      dir_r       <= dir_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    pend_dir_r  <= pend_dir_nxt;
    pend_addr_r <= pend_addr_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    mask_r      <= mask_nxt;
    res_kind_r  <= res_kind_nxt;
    res_dx_r    <= res_dx_nxt;
    res_dy_r    <= res_dy_nxt;
    out_kind_r  <= out_kind_nxt;
    out_dx_r    <= out_dx_nxt;
    out_dy_r    <= out_dy_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    dir_nxt       = dir_r;
    pend_nxt      = pend_r;
    pend_dir_nxt  = pend_dir_r;
    pend_addr_nxt = pend_addr_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    mask_nxt      = mask_r;
    res_kind_nxt  = res_kind_r;
    res_dx_nxt    = res_dx_r;
    res_dy_nxt    = res_dy_r;
    out_kind_nxt  = out_kind_r;
    out_dx_nxt    = out_dx_r;
    out_dy_nxt    = out_dy_r;
    // Drop the output beat once taken
    out_valid_nxt = out_valid_r && out_stall;
    vis_we        = 1'b0;
    vis_waddr     = pend_addr_r;
    vis_wdata     = 1'b0;
    stk_we        = 1'b0;

    case (state_r)
      gdfs_pkg::ST_CLEAR: begin
        // Sweep the visited map to zero after reset
        vis_we       = 1'b1;
        vis_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + VAW'(1);
        if (clr_addr_r == VAW'(gdfs_pkg::VIS_DEPTH - 1)) begin
          state_nxt = gdfs_pkg::ST_IDLE;
        end
      end

      gdfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          col_nxt  = in_cur_col;
          row_nxt  = in_cur_row;
          mask_nxt = in_walkable_mask;
          dir_nxt  = '0;
          pend_nxt = 1'b0;
          // A full stack cannot advance; it is never empty
          state_nxt = cnt_full ? gdfs_pkg::ST_POP_RD : gdfs_pkg::ST_SCAN;
        end
      end

      gdfs_pkg::ST_SCAN: begin
        // Issue the read for this direction, check the one issued last cycle
        pend_nxt      = cand;
        pend_dir_nxt  = dir_r[gdfs_pkg::DIR_W-1:0];
        pend_addr_nxt = nbr.addr;
        if (!dir_r[gdfs_pkg::DIR_W]) begin
          dir_nxt = dir_r + gdfs_pkg::DCNT_W'(1);
        end
        if (pend_r && !vis_rdata) begin
          // Mark, push, advance
          vis_we       = 1'b1;
          vis_waddr    = pend_addr_r;
          vis_wdata    = 1'b1;
          stk_we       = 1'b1;
          cnt_nxt      = cnt_r + CW'(1);
          pend_nxt     = 1'b0;
          res_kind_nxt = gdfs_pkg::MK_ADVANCE;
          res_dx_nxt   = gdfs_pkg::dir_dx(pend_dir_r);
          res_dy_nxt   = gdfs_pkg::dir_dy(pend_dir_r);
          state_nxt    = gdfs_pkg::ST_DONE;
        end else if (dir_r[gdfs_pkg::DIR_W] && !pend_r) begin
          // No neighbor qualified
          if (cnt_r == '0) begin
            res_kind_nxt = gdfs_pkg::MK_STUCK;
            res_dx_nxt   = 2'sd0;
            res_dy_nxt   = 2'sd0;
            state_nxt    = gdfs_pkg::ST_DONE;
          end else begin
            state_nxt = gdfs_pkg::ST_POP_RD;
          end
        end
      end

      gdfs_pkg::ST_POP_RD: begin
        // Stack read of the top entry is in flight
        state_nxt = gdfs_pkg::ST_POP_WAIT;
      end

      gdfs_pkg::ST_POP_WAIT: begin
        cnt_nxt      = cnt_dec;
        res_kind_nxt = gdfs_pkg::MK_BACKTRACK;
        res_dx_nxt   = pop_dx;
        res_dy_nxt   = pop_dy;
        state_nxt    = gdfs_pkg::ST_DONE;
      end

      gdfs_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_dx_nxt    = res_dx_r;
          out_dy_nxt    = res_dy_r;
          state_nxt     = gdfs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gdfs_pkg::ST_IDLE;
      end
    endcase
  end

  // Stack depth never exceeds its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(gdfs_pkg::STACK_DEPTH))
    else $error("stack count above depth");

  // A new output beat comes only from the result stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == gdfs_pkg::ST_DONE)
    else $error("output loaded outside result stage");

  // Marking a cell during the scan pushes exactly one entry
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdfs_pkg::ST_SCAN && vis_we) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("mark without matching push");

  // A pop leaves one entry fewer
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gdfs_pkg::ST_POP_WAIT |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("pop did not decrement stack count");

endmodule
